// ----- design/exact_price_order_matcher_unit_assert.svh -----
// Assertion macros used by the order matcher checker.
`ifndef EXACT_PRICE_ORDER_MATCHER_UNIT_ASSERT_SVH
`define EXACT_PRICE_ORDER_MATCHER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define EPOM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define EPOM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/epom_pkg.sv -----
package epom_pkg;

  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned ID_W    = 32;
  localparam int unsigned QTY_W   = 24;

  localparam int unsigned PRICE_LEVELS_DEF = 256;
  localparam int unsigned LEVEL_DEPTH_DEF  = 16;

  // Most resting orders matched by one incoming order.
  localparam int unsigned MAX_MATCH = 16;
  localparam int unsigned MATCH_W   = $clog2(MAX_MATCH + 1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_META_LAT,
    ST_CHECK,
    ST_ENT_LAT,
    ST_FINISH,
    ST_DONE_EMIT
  } state_t;

endpackage

// ----- design/epom_in_if.sv -----
interface epom_in_if;
  import epom_pkg::*;

  logic               valid;
  logic               ready;
  logic               side;
  logic [LEVEL_W-1:0] price_level;
  logic [ID_W-1:0]    ord_id;
  logic [QTY_W-1:0]   quantity;

  modport source (output valid, side, price_level, ord_id, quantity, input ready);
  modport sink   (input valid, side, price_level, ord_id, quantity, output ready);
endinterface

// ----- design/epom_out_if.sv -----
interface epom_out_if;
  import epom_pkg::*;

  logic             valid;
  logic             ready;
  logic [ID_W-1:0]  matched_id;
  logic             has_match;
  logic [QTY_W-1:0] remaining_qty;
  logic             rested;
  logic             dropped;
  logic             last;

  modport source (output valid, matched_id, has_match, remaining_qty, rested, dropped, last,
                  input ready);
  modport sink   (input valid, matched_id, has_match, remaining_qty, rested, dropped, last,
                  output ready);
endinterface

// ----- design/exact_price_order_matcher_unit.sv -----
// Exact-price order matcher. Each input beat is one buy or sell order; it is matched
// oldest first against resting orders of the opposite side at the same price level,
// and one output beat is given per matched resting order (or one no-match beat), the
// final one flagged last and carrying whether the remainder rested or was dropped.
// One order is handled at a time and in_ready is low while it is worked on. After its
// beat is accepted an order keeps the block busy while its level entry is fetched,
// each matched resting order is read and then compared and updated in the single-port
// order memory, and its results wait for room at the output. A price_level out of range
// is first folded into range by repeated subtraction of PRICE_LEVELS. After reset a
// clearing pass empties every level before the first beat is taken.
module exact_price_order_matcher_unit #(
  parameter int unsigned PRICE_LEVELS = epom_pkg::PRICE_LEVELS_DEF,
  parameter int unsigned LEVEL_DEPTH  = epom_pkg::LEVEL_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  epom_in_if.sink    in_ch,
  epom_out_if.source out_ch
);
  import epom_pkg::*;

  // Widths of the level index, queue slot, fill count and order memory address.
  localparam int unsigned LW = (PRICE_LEVELS > 1) ? $clog2(PRICE_LEVELS) : 1;
  localparam int unsigned SW = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LEVEL_DEPTH + 1);
  localparam int unsigned SLOTS = PRICE_LEVELS * LEVEL_DEPTH;
  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Per-level bookkeeping: side of the resting orders, oldest slot, fill count.
  typedef struct packed {
    logic          side;
    logic [SW-1:0] head;
    logic [CW-1:0] count;
  } meta_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [QTY_W-1:0] qty;
  } entry_t;

  // Level table and order ring buffers. Both are single-port with registered reads.
  meta_t  meta_mem [PRICE_LEVELS];
  entry_t ent_mem  [SLOTS];

  state_t state_r, state_nxt;

  logic [LW-1:0]      clr_r, clr_nxt;
  logic               side_r, side_nxt;
  logic [LEVEL_W-1:0] lvl_r, lvl_nxt;
  logic [ID_W-1:0]    id_r, id_nxt;
  logic [QTY_W-1:0]   q_r, q_nxt;
  logic               mside_r, mside_nxt;
  logic [SW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [MATCH_W-1:0] n_r, n_nxt;
  logic               rested_r, rested_nxt;
  logic               dropped_r, dropped_nxt;

  // Pending result: held back until it is known whether another one follows.
  logic               pend_v_r, pend_v_nxt;
  logic [ID_W-1:0]    pend_id_r, pend_id_nxt;
  logic               pend_hit_r, pend_hit_nxt;
  logic [QTY_W-1:0]   pend_rem_r, pend_rem_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]    out_id_r, out_id_nxt;
  logic               out_hit_r, out_hit_nxt;
  logic [QTY_W-1:0]   out_rem_r, out_rem_nxt;
  logic               out_rested_r, out_rested_nxt;
  logic               out_dropped_r, out_dropped_nxt;
  logic               out_last_r, out_last_nxt;

  // Memory ports.
  logic          meta_re, meta_we;
  logic [LW-1:0] meta_raddr, meta_waddr;
  meta_t         meta_wdata, meta_q;
  logic          ent_re, ent_we;
  logic [AW-1:0] ent_raddr, ent_waddr;
  entry_t        ent_wdata, ent_q;

  logic [LW-1:0]  lvl_idx;
  logic           out_free;
  logic [SW-1:0]  head_inc;
  logic [CW:0]    pos_sum;
  logic [SW-1:0]  tail_pos;
  logic [AW-1:0]  head_addr, tail_addr;
  logic           take_all;
  logic [QTY_W-1:0] q_after;
  logic           rest_ok;
  logic           side_new;

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (meta_re) begin
      meta_q <= meta_mem[meta_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_q <= ent_mem[ent_raddr];
    end
  end

  // The level index is valid once the fold below has brought lvl_r into range.
  assign lvl_idx = LW'(lvl_r);
  assign out_free = !out_valid_r || out_ch.ready;

  // Ring arithmetic for the oldest slot and the first free slot of the level.
  assign head_inc = (head_r == SW'(LEVEL_DEPTH - 1)) ? '0 : head_r + SW'(1);
  assign pos_sum  = (CW + 1)'(head_r) + (CW + 1)'(cnt_r);
  assign tail_pos = (pos_sum >= (CW + 1)'(LEVEL_DEPTH)) ?
                    SW'(pos_sum - (CW + 1)'(LEVEL_DEPTH)) : SW'(pos_sum);
  assign head_addr = AW'(lvl_idx) * AW'(LEVEL_DEPTH) + AW'(head_r);
  assign tail_addr = AW'(lvl_idx) * AW'(LEVEL_DEPTH) + AW'(tail_pos);

  // One compare and subtract serves every match step.
  assign take_all = (q_r >= ent_q.qty);
  assign q_after  = take_all ? (q_r - ent_q.qty) : '0;

  // An empty level takes the side of the incoming order before the remainder is queued.
  assign side_new = (q_r != '0 && cnt_r == '0) ? side_r : mside_r;
  assign rest_ok  = (q_r != '0) && (side_new == side_r) &&
                    ((CW + 1)'(cnt_r) < (CW + 1)'(LEVEL_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    side_r        <= side_nxt;
    lvl_r         <= lvl_nxt;
    id_r          <= id_nxt;
    q_r           <= q_nxt;
    mside_r       <= mside_nxt;
    head_r        <= head_nxt;
    cnt_r         <= cnt_nxt;
    n_r           <= n_nxt;
    rested_r      <= rested_nxt;
    dropped_r     <= dropped_nxt;
    pend_id_r     <= pend_id_nxt;
    pend_hit_r    <= pend_hit_nxt;
    pend_rem_r    <= pend_rem_nxt;
    out_id_r      <= out_id_nxt;
    out_hit_r     <= out_hit_nxt;
    out_rem_r     <= out_rem_nxt;
    out_rested_r  <= out_rested_nxt;
    out_dropped_r <= out_dropped_nxt;
    out_last_r    <= out_last_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    side_nxt        = side_r;
    lvl_nxt         = lvl_r;
    id_nxt          = id_r;
    q_nxt           = q_r;
    mside_nxt       = mside_r;
    head_nxt        = head_r;
    cnt_nxt         = cnt_r;
    n_nxt           = n_r;
    rested_nxt      = rested_r;
    dropped_nxt     = dropped_r;
    pend_v_nxt      = pend_v_r;
    pend_id_nxt     = pend_id_r;
    pend_hit_nxt    = pend_hit_r;
    pend_rem_nxt    = pend_rem_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_id_nxt      = out_id_r;
    out_hit_nxt     = out_hit_r;
    out_rem_nxt     = out_rem_r;
    out_rested_nxt  = out_rested_r;
    out_dropped_nxt = out_dropped_r;
    out_last_nxt    = out_last_r;

    meta_re    = 1'b0;
    meta_raddr = lvl_idx;
    meta_we    = 1'b0;
    meta_waddr = lvl_idx;
    meta_wdata = '{side: side_new, head: head_r, count: cnt_r};
    ent_re     = 1'b0;
    ent_raddr  = head_addr;
    ent_we     = 1'b0;
    ent_waddr  = head_addr;
    ent_wdata  = '{id: ent_q.id, qty: ent_q.qty - q_r};

    unique case (state_r)
      ST_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_r;
        meta_wdata = '0;
        clr_nxt    = clr_r + LW'(1);
        if (clr_r == LW'(PRICE_LEVELS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          side_nxt  = in_ch.side;
          lvl_nxt   = in_ch.price_level;
          id_nxt    = in_ch.ord_id;
          q_nxt     = in_ch.quantity;
          n_nxt     = '0;
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        // Fold an out-of-range level by repeated subtraction, then fetch its entry.
        if (32'(lvl_r) >= PRICE_LEVELS) begin
          lvl_nxt = lvl_r - LEVEL_W'(PRICE_LEVELS);
        end else begin
          meta_re   = 1'b1;
          state_nxt = ST_META_LAT;
        end
      end
      ST_META_LAT: begin
        mside_nxt = meta_q.side;
        head_nxt  = meta_q.head;
        cnt_nxt   = meta_q.count;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (q_r != '0 && cnt_r != '0 && mside_r != side_r && n_r < MATCH_W'(MAX_MATCH)) begin
          ent_re    = 1'b1;
          state_nxt = ST_ENT_LAT;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_ENT_LAT: begin
        // A result held back from the previous match goes out first; wait for room.
        if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            out_valid_nxt   = 1'b1;
            out_id_nxt      = pend_id_r;
            out_hit_nxt     = pend_hit_r;
            out_rem_nxt     = pend_rem_r;
            out_rested_nxt  = 1'b0;
            out_dropped_nxt = 1'b0;
            out_last_nxt    = 1'b0;
          end
          if (take_all) begin
            head_nxt = head_inc;
            cnt_nxt  = cnt_r - CW'(1);
          end else begin
            ent_we = 1'b1;
          end
          q_nxt        = q_after;
          n_nxt        = n_r + MATCH_W'(1);
          pend_v_nxt   = 1'b1;
          pend_id_nxt  = ent_q.id;
          pend_hit_nxt = 1'b1;
          pend_rem_nxt = q_after;
          state_nxt    = ST_CHECK;
        end
      end
      ST_FINISH: begin
        meta_we   = 1'b1;
        ent_waddr = tail_addr;
        ent_wdata = '{id: id_r, qty: q_r};
        if (rest_ok) begin
          ent_we          = 1'b1;
          meta_wdata.count = cnt_r + CW'(1);
        end
        rested_nxt  = rest_ok;
        dropped_nxt = (q_r != '0) && !rest_ok;
        if (!pend_v_r) begin
          pend_v_nxt   = 1'b1;
          pend_id_nxt  = '0;
          pend_hit_nxt = 1'b0;
          pend_rem_nxt = q_r;
        end
        state_nxt = ST_DONE_EMIT;
      end
      ST_DONE_EMIT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_id_nxt      = pend_id_r;
          out_hit_nxt     = pend_hit_r;
          out_rem_nxt     = pend_rem_r;
          out_rested_nxt  = rested_r;
          out_dropped_nxt = dropped_r;
          out_last_nxt    = 1'b1;
          pend_v_nxt      = 1'b0;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.matched_id    = out_id_r;
  assign out_ch.has_match     = out_hit_r;
  assign out_ch.remaining_qty = out_rem_r;
  assign out_ch.rested        = out_rested_r;
  assign out_ch.dropped       = out_dropped_r;
  assign out_ch.last          = out_last_r;

endmodule

// ----- design/epom_checker.sv -----
module epom_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [epom_pkg::ID_W-1:0] out_matched_id,
  input logic                      out_has_match,
  input logic [epom_pkg::QTY_W-1:0] out_remaining_qty,
  input logic                      out_rested,
  input logic                      out_dropped,
  input logic                      out_last
);
  `include "exact_price_order_matcher_unit_assert.svh"

  // A stalled result stays offered with its id, remainder and last flag unchanged.
  `EPOM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_matched_id) && $stable(out_remaining_qty) && $stable(out_last))

  // A no-match result is the only result of its order and carries id zero.
  `EPOM_ASSERT_IMPL(a_nomatch_last, clk, rst_n, out_valid && !out_has_match, out_last && out_matched_id == '0)

  // A remainder either rests or is dropped, never both.
  `EPOM_ASSERT_IMPL(a_rest_xor_drop, clk, rst_n, out_valid, !(out_rested && out_dropped))

  // Only the final result reports the fate of the remainder, and only when one is left.
  `EPOM_ASSERT_IMPL(a_fate_on_last, clk, rst_n, out_valid && (out_rested || out_dropped), out_last && out_remaining_qty != '0)

endmodule

bind exact_price_order_matcher_unit epom_checker u_epom_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_matched_id    (out_ch.matched_id),
  .out_has_match     (out_ch.has_match),
  .out_remaining_qty (out_ch.remaining_qty),
  .out_rested        (out_ch.rested),
  .out_dropped       (out_ch.dropped),
  .out_last          (out_ch.last)
);

// ----- tb/sv/tb_stub_unused.sv -----
`timescale 1ns / 100ps
// Shared beat record used by the order matcher testbench.
package tb_book_pkg;
  import epom_pkg::*;

  typedef struct packed {
    logic [ID_W-1:0]  matched_id;
    logic             has_match;
    logic [QTY_W-1:0] remaining_qty;
    logic             rested;
    logic             dropped;
    logic             last;
  } fill_rec_t;
endpackage

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;
  import epom_pkg::*;
  import tb_book_pkg::*;

  localparam int unsigned LEVELS = PRICE_LEVELS_DEF;
  localparam int unsigned DEPTH  = LEVEL_DEPTH_DEF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #6 clk = ~clk;

  epom_in_if  in_ch ();
  epom_out_if out_ch ();

  exact_price_order_matcher_unit uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // The testbench keeps its own copy of the order book. Each level is a ring
  // of DEPTH slots; only occupied slots are ever read.
  logic             book_side [LEVELS];
  int unsigned      book_head [LEVELS];
  int unsigned      book_count[LEVELS];
  logic [ID_W-1:0]  book_id   [LEVELS*DEPTH];
  logic [QTY_W-1:0] book_qty  [LEVELS*DEPTH];

  // Fills predicted for accepted orders, oldest at the front.
  fill_rec_t pending_fills[$];

  int mismatches = 0;
  int fills_seen = 0;
  int orders_sent = 0;
  int drops_seen = 0;
  bit drain_mode = 1'b0;
  logic [ID_W-1:0] id_seq = 32'h100;

  // Work out the beats one order produces and update the book copy.
  task automatic book_apply(input logic side, input logic [7:0] lvl_in,
                            input logic [ID_W-1:0] oid, input logic [QTY_W-1:0] qty);
    int unsigned lvl;
    int unsigned base;
    int unsigned slot;
    int unsigned pos;
    int n;
    logic [QTY_W-1:0] left;
    fill_rec_t rec;
    fill_rec_t batch[$];
    logic rest_flag;
    logic drop_flag;
    lvl = lvl_in % LEVELS;
    base = lvl * DEPTH;
    left = qty;
    n = 0;
    rest_flag = 1'b0;
    drop_flag = 1'b0;
    if (book_count[lvl] > 0 && book_side[lvl] != side) begin
      while (left > 0 && book_count[lvl] > 0 && n < MAX_MATCH) begin
        slot = base + book_head[lvl];
        if (left >= book_qty[slot]) begin
          left -= book_qty[slot];
          book_head[lvl] = (book_head[lvl] + 1) % DEPTH;
          book_count[lvl]--;
        end else begin
          book_qty[slot] -= left;
          left = '0;
        end
        rec = '{matched_id: book_id[slot], has_match: 1'b1, remaining_qty: left,
                rested: 1'b0, dropped: 1'b0, last: 1'b0};
        batch.insert(batch.size(), rec);
        n++;
      end
    end
    if (left > 0) begin
      if (book_count[lvl] == 0) book_side[lvl] = side;
      if (book_side[lvl] == side && book_count[lvl] < DEPTH) begin
        pos = (book_head[lvl] + book_count[lvl]) % DEPTH;
        book_id[base + pos] = oid;
        book_qty[base + pos] = left;
        book_count[lvl]++;
        rest_flag = 1'b1;
      end else begin
        drop_flag = 1'b1;
      end
    end
    if (n == 0) begin
      rec = '{matched_id: '0, has_match: 1'b0, remaining_qty: left,
              rested: 1'b0, dropped: 1'b0, last: 1'b0};
      batch.insert(batch.size(), rec);
    end
    batch[batch.size()-1].rested = rest_flag;
    batch[batch.size()-1].dropped = drop_flag;
    batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) pending_fills.insert(pending_fills.size(), batch[i]);
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Drive one order beat and hold it until the block takes it. The valid stays
  // high after acceptance; it drops only when a gap follows or the book is drained.
  task automatic send_order(input logic side, input logic [7:0] lvl,
                            input logic [ID_W-1:0] oid, input logic [QTY_W-1:0] qty);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.side        <= side;
    in_ch.price_level <= lvl;
    in_ch.ord_id      <= oid;
    in_ch.quantity    <= qty;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // The beat was accepted at this edge; predict before anything else moves.
    book_apply(side, lvl, oid, qty);
    orders_sent++;
  endtask

  task automatic wait_book_quiet();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_fills.size() != 0) @(posedge clk);
  endtask

  function automatic logic [ID_W-1:0] next_id();
    id_seq = id_seq + 32'd1;
    return id_seq;
  endfunction

  // Field extremes, zero quantity, empty and opposite levels, partial fills.
  task automatic test_directed_basics();
    send_order(1'b0, 8'd0,   32'h0000_0000, 24'd0);
    send_order(1'b1, 8'd255, 32'hFFFF_FFFF, 24'hFFFFFF);
    send_order(1'b0, 8'd255, 32'h8000_0001, 24'd1);
    send_order(1'b0, 8'd255, 32'h7FFF_FFFE, 24'hFFFFFF);
    send_order(1'b0, 8'd10,  32'hA5A5_A5A5, 24'd100);
    send_order(1'b0, 8'd10,  32'h5A5A_5A5A, 24'd50);
    send_order(1'b1, 8'd10,  32'h0000_1111, 24'd30);
    send_order(1'b1, 8'd10,  32'h0000_2222, 24'd120);
    send_order(1'b1, 8'd10,  32'h0000_3333, 24'd500);
    send_order(1'b0, 8'd10,  32'h0000_4444, 24'd0);
    send_order(1'b0, 8'd10,  32'h0000_5555, 24'd499);
  endtask

  // Fill one level, overflow it, then sweep it with a single large order.
  task automatic test_full_level_sweep();
    for (int i = 0; i < DEPTH; i++) send_order(1'b1, 8'd77, next_id(), 24'(3 + i));
    send_order(1'b1, 8'd77, next_id(), 24'd9);
    send_order(1'b0, 8'd77, next_id(), 24'hFFFFFF);
  endtask

  // The sender holds off until every outstanding beat has come back.
  task automatic test_drain_pause();
    wait_book_quiet();
    send_order(1'b1, 8'd77, next_id(), 24'd1);
  endtask

  // Random orders on a handful of busy levels so queues build and match often.
  task automatic test_random_flow();
    logic [7:0] lvl;
    logic [QTY_W-1:0] qty;
    int unsigned r;
    for (int k = 0; k < 100; k++) begin
      r = $urandom_range(0, 99);
      if (r < 80) lvl = 8'($urandom_range(0, 5)) * 8'd51;
      else lvl = 8'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 5) qty = '0;
      else if (r < 12) qty = 24'($urandom);
      else qty = 24'($urandom_range(1, 40));
      send_order(1'($urandom_range(0, 1)), lvl, 32'($urandom), qty);
      if (k == 50) wait_book_quiet();
    end
  endtask

  // Result side: random back-pressure, compare every beat with the oldest fill.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 99) < 3) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(8, 25)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) < 20) ? 1'b0 : 1'b1;
      end
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        fill_rec_t got;
        fill_rec_t want;
        got = '{matched_id: out_ch.matched_id, has_match: out_ch.has_match,
                remaining_qty: out_ch.remaining_qty, rested: out_ch.rested,
                dropped: out_ch.dropped, last: out_ch.last};
        fills_seen++;
        if (pending_fills.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat id=%h rem=%0d", got.matched_id,
                                         got.remaining_qty);
        end else begin
          want = pending_fills.pop_front();
          if (want.dropped && want.last) drops_seen++;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: exp id=%h hit=%b rem=%0d r=%b d=%b l=%b",
                       want.matched_id, want.has_match, want.remaining_qty, want.rested,
                       want.dropped, want.last);
              $display("          act id=%h hit=%b rem=%0d r=%b d=%b l=%b",
                       got.matched_id, got.has_match, got.remaining_qty, got.rested,
                       got.dropped, got.last);
            end
          end
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.side = 1'b0;
    in_ch.price_level = '0;
    in_ch.ord_id = '0;
    in_ch.quantity = '0;
    for (int i = 0; i < LEVELS; i++) begin
      book_side[i] = 1'b0;
      book_head[i] = 0;
      book_count[i] = 0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_basics();
    test_full_level_sweep();
    test_drain_pause();
    test_random_flow();
    wait_book_quiet();
    repeat (100) @(posedge clk);
    $display("Sent %0d orders and checked %0d result beats, %0d of them ending in a drop.",
             orders_sent, fills_seen, drops_seen);
    if (mismatches == 0 && pending_fills.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
